[sv/bigt_pkg.sv]
package bigt_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_GRID_SPACING = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W   = 13;
   localparam int PIX_W        = 10;
   localparam int OUT_COL_W    = 11;
   localparam int OUT_ROW_W    = 12;
   localparam int FWIDTH_W     = 12;
   localparam int FHEIGHT_W    = 13;
   localparam int SPACING_W    = 8;

   localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 12'd640;
   localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 13'd480;
   localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd1;

   // one result word
   typedef struct packed {
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 keep;
      logic                 last_of_run;
      logic                 frame_done;
   } rsp_word_type;

endpackage

[sv/bigt_if.sv]
interface bigt_req_if import bigt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bigt_rsp_if import bigt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_COL_W-1:0] out_col;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 keep;
   logic                 last_of_run;
   logic                 frame_done;

   modport source (output valid, output out_col, output out_row, output keep,
                   output last_of_run, output frame_done, input ready);
   modport sink   (input valid, input out_col, input out_row, input keep,
                   input last_of_run, input frame_done, output ready);
endinterface

interface bigt_csr_if import bigt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/bigt_ram.sv]
module bigt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/binary_interior_grid_thinning.sv]
// an accepted pixel is registered in stage 1, which queues its result words for rsp
// throughput: one pixel word per cycle while the result queue has room; a last-row
//   pixel below the first row yields two result words, so last rows drain at the
//   rsp rate of one word per cycle while rsp is ready; the limit is the rsp port
// reset: synchronous active high; clears counters, phases, queue and restores the
//   size registers to 640 x 480 with grid spacing 1; the line store is not cleared
module binary_interior_grid_thinning import bigt_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic       clock,
   input  logic       reset,
   bigt_req_if.sink   req_chan,
   bigt_rsp_if.source rsp_chan,
   bigt_csr_if.sink   csr_chan
);

   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int QDEPTH  = 4;
   localparam int QPW     = $clog2(QDEPTH);
   localparam int QCW     = QPW + 1;

   // stage 1 control, captured at acceptance
   typedef struct packed {
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic          last_col;
      logic          last_row;
      logic          has_above;
      logic          cur;
      logic          col_ph0;
      logic          row_ph0;
      logic          self_hit;
   } s1_type;

   // configuration registers
   logic [FWIDTH_W-1:0]  fwidth_ff;
   logic [FHEIGHT_W-1:0] fheight_ff;
   logic [SPACING_W-1:0] spacing_ff;

   // position and phase counters
   logic [XW-1:0]        col_ff, col_in;
   logic [YW-1:0]        row_ff, row_in;
   logic [SPACING_W-1:0] col_ph_ff, col_ph_in;
   logic [SPACING_W-1:0] row_ph_ff, row_ph_in;

   // stage 1
   logic   s1_valid_ff;
   s1_type s1_ff, s1_in;

   // store word = {prev row bit, older row bit}
   logic [1:0] cword_ff, cword_in;   // word at the column now in stage 1
   logic       left_ff, left_in;
   logic       fwd_hit_ff;
   logic [1:0] fwd_data_ff;
   logic [1:0] ram_q;
   logic [1:0] word_rd;

   // result queue
   rsp_word_type     q_mem_ff [QDEPTH];
   logic [QPW-1:0]   q_wp_ff, q_rp_ff;
   logic [QCW-1:0]   q_cnt_ff;

   logic             accept;
   logic             pop;
   logic [XW:0]      w_eff;
   logic [YW:0]      h_eff;
   logic             last_col, last_row;
   logic [XW-1:0]    col_next;
   logic [1:0]       s1_n;
   logic [1:0]       wr_word;
   logic             centre, above, right, border, full, keep;
   rsp_word_type     res_above, res_own;

   // next grid phase; spacing of zero keeps the phase at zero
   function automatic logic [SPACING_W-1:0] next_phase(
      input logic [SPACING_W-1:0] p,
      input logic [SPACING_W-1:0] s
   );
      logic [SPACING_W:0] p1;
      p1 = {1'b0, p} + 1'b1;
      if (p1 >= {1'b0, s}) begin
         return '0;
      end
      return p1[SPACING_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // configuration port, always ready
   // ---------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= FWIDTH_RESET;
         fheight_ff <= FHEIGHT_RESET;
         spacing_ff <= SPACING_RESET;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_FRAME_WIDTH:  fwidth_ff  <= csr_chan.wdata[FWIDTH_W-1:0];
            CSR_FRAME_HEIGHT: fheight_ff <= csr_chan.wdata[FHEIGHT_W-1:0];
            CSR_GRID_SPACING: spacing_ff <= csr_chan.wdata[SPACING_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero acts as one, oversize clamps to the store depth
   always_comb begin
      if (fwidth_ff == '0) begin
         w_eff = (XW+1)'(1);
      end else if (32'(fwidth_ff) > 32'(MAX_WIDTH)) begin
         w_eff = (XW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (XW+1)'(fwidth_ff);
      end
      if (fheight_ff == '0) begin
         h_eff = (YW+1)'(1);
      end else if (32'(fheight_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = (YW+1)'(MAX_HEIGHT);
      end else begin
         h_eff = (YW+1)'(fheight_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // stage 0: acceptance, counters and store read of the next column
   // ---------------------------------------------------------------------------
   // queue holds 4 words; reserve room for what stage 1 is about to push plus 2
   assign s1_n        = s1_valid_ff ? (2'(s1_ff.has_above) + 2'(s1_ff.last_row)) : 2'd0;
   assign req_chan.ready = (q_cnt_ff + QCW'(s1_n)) <= QCW'(QDEPTH - 2);
   assign accept      = req_chan.valid && req_chan.ready;

   always_comb begin
      last_col  = ({1'b0, col_ff} + 1'b1) >= w_eff;
      last_row  = ({1'b0, row_ff} + 1'b1) >= h_eff;
      col_next  = last_col ? '0 : col_ff + 1'b1;

      col_in    = col_ff;
      row_in    = row_ff;
      col_ph_in = col_ph_ff;
      row_ph_in = row_ph_ff;
      if (accept) begin
         col_in = col_next;
         if (last_col) begin
            col_ph_in = '0;
            if (last_row) begin
               row_in    = '0;
               row_ph_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (row_ff != '0) begin
                  row_ph_in = next_phase(row_ph_ff, spacing_ff);
               end
            end
         end else begin
            col_ph_in = next_phase(col_ph_ff, spacing_ff);
         end
      end

      s1_in.x         = col_ff;
      s1_in.y         = row_ff;
      s1_in.last_col  = last_col;
      s1_in.last_row  = last_row;
      s1_in.has_above = (row_ff != '0);
      s1_in.cur       = (req_chan.pixel_value != '0);
      s1_in.col_ph0   = (col_ph_ff == '0);
      s1_in.row_ph0   = (row_ph_ff == '0);
      // single-column frame: the word read for the next pixel is this pixel's own
      s1_in.self_hit  = (col_next == col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         col_ph_ff   <= '0;
         row_ph_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_ph_ff   <= col_ph_in;
         row_ph_ff   <= row_ph_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // line store: one ram of 2-bit words, read one column ahead
   // ---------------------------------------------------------------------------
   assign wr_word = {s1_ff.cur, centre};

   bigt_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.x),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (col_next),
      .rd_data (ram_q)
   );

   // read and write of the same column in one cycle: forward the written word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= accept && s1_valid_ff && (col_next == s1_ff.x);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_word;
   end

   assign word_rd = fwd_hit_ff ? fwd_data_ff : ram_q;

   // ---------------------------------------------------------------------------
   // stage 1: neighbour test and result words
   // ---------------------------------------------------------------------------
   always_comb begin
      centre = cword_ff[1];
      above  = cword_ff[0];
      right  = word_rd[1];
      border = (s1_ff.y == YW'(1)) || (s1_ff.x == '0) || s1_ff.last_col;
      full   = left_ff && right && above && s1_ff.cur;
      keep   = !border && centre && (!full || (s1_ff.col_ph0 && s1_ff.row_ph0));

      res_above.out_col     = OUT_COL_W'(s1_ff.x);
      res_above.out_row     = OUT_ROW_W'(s1_ff.y - 1'b1);
      res_above.keep        = keep;
      res_above.last_of_run = !s1_ff.last_row;
      res_above.frame_done  = 1'b0;

      res_own.out_col       = OUT_COL_W'(s1_ff.x);
      res_own.out_row       = OUT_ROW_W'(s1_ff.y);
      res_own.keep          = 1'b0;
      res_own.last_of_run   = 1'b1;
      res_own.frame_done    = s1_ff.last_col;

      // word for the next column, unless this pixel rewrote it
      cword_in = cword_ff;
      left_in  = left_ff;
      if (s1_valid_ff) begin
         cword_in = s1_ff.self_hit ? wr_word : word_rd;
         left_in  = centre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      cword_ff <= cword_in;
   end

   // ---------------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------------
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         if (s1_ff.has_above) begin
            q_mem_ff[q_wp_ff] <= res_above;
            if (s1_ff.last_row) begin
               q_mem_ff[q_wp_ff + 1'b1] <= res_own;
            end
         end else if (s1_ff.last_row) begin
            q_mem_ff[q_wp_ff] <= res_own;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= '0;
         q_rp_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wp_ff  <= q_wp_ff + QPW'(s1_n);
         q_rp_ff  <= q_rp_ff + QPW'(pop);
         q_cnt_ff <= q_cnt_ff + QCW'(s1_n) - QCW'(pop);
      end
   end

   assign rsp_chan.valid       = (q_cnt_ff != '0);
   assign rsp_chan.out_col     = q_mem_ff[q_rp_ff].out_col;
   assign rsp_chan.out_row     = q_mem_ff[q_rp_ff].out_row;
   assign rsp_chan.keep        = q_mem_ff[q_rp_ff].keep;
   assign rsp_chan.last_of_run = q_mem_ff[q_rp_ff].last_of_run;
   assign rsp_chan.frame_done  = q_mem_ff[q_rp_ff].frame_done;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QCW'(QDEPTH))
      else $error("result queue overfilled");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.last_row && s1_ff.last_col |->
         (row_ff == '0) && (col_ff == '0) && (row_ph_ff == '0))
      else $error("counters did not wrap at end of frame");

   a_done_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_done |-> rsp_chan.last_of_run && !rsp_chan.keep)
      else $error("frame end word malformed");

   a_keep_inner: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.keep |->
         (rsp_chan.out_row != '0) && (rsp_chan.out_col != '0))
      else $error("border pixel kept");

endmodule

[verif/binary_interior_grid_thinning_test.sv]
module binary_interior_grid_thinning_test import bigt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LINE_MAX       = 2048;
   localparam int          FRAME_ROWS_MAX = 4096;
   localparam int          RAND_PIXELS    = 700;
   localparam int          DRAIN_CYCLES   = 4;
   localparam int unsigned RUN_LIMIT      = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bigt_req_if req_chan ();
   bigt_rsp_if rsp_chan ();
   bigt_csr_if csr_chan ();

   binary_interior_grid_thinning #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (FRAME_ROWS_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // thinning predictor: its own copy of the size registers, the two line
   // stores, the raster position and the grid phases
   // --------------------------------------------------------------------
   logic [FWIDTH_W-1:0]  frame_w_reg = FWIDTH_RESET;
   logic [FHEIGHT_W-1:0] frame_h_reg = FHEIGHT_RESET;
   logic [SPACING_W-1:0] pitch_reg   = SPACING_RESET;

   bit          row_near [LINE_MAX];   // row just above the incoming pixel
   bit          row_far  [LINE_MAX];   // the row above that
   bit          left_px;               // centre bit of the previous column
   int unsigned at_col, at_row;        // raster position of the incoming pixel
   int unsigned col_grid, row_grid;    // column phase and emitted-row phase

   rsp_word_type       keep_words_due [$];   // result words still to arrive
   logic [PIX_W-1:0]   pixel_feed     [$];   // pixel words not yet offered

   int unsigned grid_dropped, kept_count, words_checked;
   int unsigned pixels_fed, frames_run, fail_count;

   // phase advance wraps at the spacing; spacing 0 keeps the phase at 0
   function automatic int unsigned grid_advance(int unsigned p);
      return (p + 1 >= int'(pitch_reg)) ? 0 : ((p + 1) & 8'hff);
   endfunction

   function automatic void thin_pixel(logic [PIX_W-1:0] pix);
      int unsigned  w, h, x, y;
      bit           last_col, last_row, cur, centre, keep;
      rsp_word_type word;
      // zero sizes act as 1, oversized ones clamp to the store depth
      w = (frame_w_reg == 0) ? 1 :
          (int'(frame_w_reg) > LINE_MAX) ? LINE_MAX : int'(frame_w_reg);
      h = (frame_h_reg == 0) ? 1 :
          (int'(frame_h_reg) > FRAME_ROWS_MAX) ? FRAME_ROWS_MAX : int'(frame_h_reg);
      x = at_col;
      y = at_row;
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      cur      = (pix != 0);
      centre   = (x < LINE_MAX) && row_near[x];
      // result for the pixel one row up, none on the first row
      if (y >= 1) begin
         keep = 1'b0;
         if (!(y == 1 || x == 0 || last_col) && centre) begin
            if (left_px && (x + 1 < LINE_MAX) && row_near[x + 1] && row_far[x] && cur) begin
               // fully surrounded: only grid points survive
               keep = (col_grid == 0 && row_grid == 0);
               if (!keep)
                  grid_dropped++;
            end else begin
               keep = 1'b1;   // edge of the shape
            end
         end
         word.out_col     = OUT_COL_W'(x);
         word.out_row     = OUT_ROW_W'(y - 1);
         word.keep        = keep;
         word.last_of_run = !last_row;
         word.frame_done  = 1'b0;
         keep_words_due.push_back(word);
      end
      // last row also reports its own border pixel, cleared
      if (last_row) begin
         word.out_col     = OUT_COL_W'(x);
         word.out_row     = OUT_ROW_W'(y);
         word.keep        = 1'b0;
         word.last_of_run = 1'b1;
         word.frame_done  = last_col;
         keep_words_due.push_back(word);
      end
      // shift the line stores
      if (x < LINE_MAX) begin
         row_far[x]  = centre;
         row_near[x] = cur;
      end
      left_px = centre;
      // raster and phase counters
      if (last_col) begin
         at_col   = 0;
         col_grid = 0;
         if (last_row) begin
            at_row   = 0;
            row_grid = 0;
         end else begin
            if (y >= 1)
               row_grid = grid_advance(row_grid);
            at_row = y + 1;
         end
      end else begin
         at_col   = x + 1;
         col_grid = grid_advance(col_grid);
      end
   endfunction

   // --------------------------------------------------------------------
   // mismatch reporting
   // --------------------------------------------------------------------
   task automatic flag_mismatch(string msg);
      fail_count++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [11:0] got, logic [11:0] want,
                              rsp_word_type ref_word);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0d want %0d (col %0d row %0d)", name, got, want,
                                 ref_word.out_col, ref_word.out_row));
   endtask

   // --------------------------------------------------------------------
   // idling: each side draws a wait per word, calm stretches draw none
   // --------------------------------------------------------------------
   bit req_calm, rsp_calm;

   function automatic int unsigned pick_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // --------------------------------------------------------------------
   // pixel driver: changes inputs on the falling edge
   // --------------------------------------------------------------------
   int unsigned req_words_sent, req_words_taken, req_gap;

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.pixel_value <= '0;
         req_gap = 0;
      end else if (req_words_taken == req_words_sent) begin
         // previous word taken (or none offered): gap, next word, or idle
         if (req_gap > 0) begin
            req_chan.valid <= 1'b0;
            req_gap--;
         end else if (pixel_feed.size() != 0) begin
            req_chan.valid       <= 1'b1;
            req_chan.pixel_value <= pixel_feed.pop_front();
            req_words_sent++;
            req_gap = pick_wait(req_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // pixel word accepted: run the predictor
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         req_words_taken++;
         thin_pixel(req_chan.pixel_value);
      end
   end

   // --------------------------------------------------------------------
   // result side: ready stalls drawn per word, checked on the rising edge
   // --------------------------------------------------------------------
   int unsigned rsp_words_taken, rsp_words_seen, rsp_stall;

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_words_taken != rsp_words_seen) begin
            rsp_words_seen = rsp_words_taken;
            rsp_stall      = pick_wait(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_words_taken++;
         if (keep_words_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result word col %0d row %0d",
                                    rsp_chan.out_col, rsp_chan.out_row));
         end else begin
            want = keep_words_due.pop_front();
            check_field("out_col", 12'(rsp_chan.out_col), 12'(want.out_col), want);
            check_field("out_row", 12'(rsp_chan.out_row), 12'(want.out_row), want);
            check_field("keep", 12'(rsp_chan.keep), 12'(want.keep), want);
            check_field("last_of_run", 12'(rsp_chan.last_of_run), 12'(want.last_of_run),
                        want);
            check_field("frame_done", 12'(rsp_chan.frame_done), 12'(want.frame_done),
                        want);
            words_checked++;
            if (want.keep)
               kept_count++;
         end
      end
   end

   // --------------------------------------------------------------------
   // watchdog
   // --------------------------------------------------------------------
   int unsigned cycle_count;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, keep_words_due.size());
         $display("binary_interior_grid_thinning regression: fail");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // register writes, only with the block idle
   // --------------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= data;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      case (idx)
         CSR_FRAME_WIDTH:  frame_w_reg = data[FWIDTH_W-1:0];
         CSR_FRAME_HEIGHT: frame_h_reg = data[FHEIGHT_W-1:0];
         CSR_GRID_SPACING: pitch_reg   = data[SPACING_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_frame(int unsigned w, int unsigned h, int unsigned s);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_GRID_SPACING, CSR_DATA_W'(s));
   endtask

   // wait until every pixel is taken and every result word is back, then let
   // the pipeline run dry
   task automatic settle();
      while (pixel_feed.size() != 0 || req_words_taken != req_words_sent ||
             keep_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // a run of random pixels at a given fill percentage, not tied to a frame
   task automatic feed_pixels(int unsigned n, int unsigned pct);
      for (int unsigned i = 0; i < n; i++)
         pixel_feed.push_back(($urandom_range(0, 99) < pct) ? PIX_W'($urandom_range(1, 765))
                                                            : '0);
      pixels_fed += n;
      settle();
   endtask

   // one whole frame of random pixels at a given fill percentage
   task automatic feed_frame(int unsigned w, int unsigned h, int unsigned pct);
      int unsigned cols, rows;
      cols = (w == 0) ? 1 : (w > LINE_MAX) ? LINE_MAX : w;
      rows = (h == 0) ? 1 : (h > FRAME_ROWS_MAX) ? FRAME_ROWS_MAX : h;
      frames_run++;
      feed_pixels(cols * rows, pct);
   endtask

   // --------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------
   // set values walking every pixel bit, plus the value 765
   logic [PIX_W-1:0] set_vals [11] = '{10'd765, 10'd1, 10'd2, 10'd4, 10'd8, 10'd16,
                                       10'd32, 10'd64, 10'd128, 10'd256, 10'd512};
   // size extremes: single pixel, zero width, zero height, two columns, a wide
   // two-row frame, the smallest frame with an interior
   int unsigned sweep_w [6] = '{ 1,   0,  3,  2,  40,   3};
   int unsigned sweep_h [6] = '{ 1,   5,  0,  3,   2,   3};
   int unsigned sweep_s [6] = '{ 0, 255,  3,  7,   2,   1};
   int unsigned sweep_p [6] = '{70,  90, 50, 50, 100, 100};
   int unsigned fill_pct [5] = '{100, 90, 70, 40, 5};

   initial begin
      int unsigned w, h, s, rand_start;

      req_chan.valid       = 1'b0;
      req_chan.pixel_value = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_FRAME_WIDTH;
      csr_chan.wdata       = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a solid 5x5 shape at spacing 2 with one hole inside, so the
      // grid point is kept, off-grid interior pixels drop and the hole makes
      // its neighbours edge pixels; first row, last row and frame end included
      set_frame(5, 5, 2);
      for (int i = 0; i < 25; i++)
         pixel_feed.push_back((i == 18) ? '0 : set_vals[i % 11]);
      pixels_fed += 25;
      frames_run++;
      settle();

      // register extremes: zero and one-pixel sizes, spacing 0 and 255, and
      // the unused register index
      write_csr(CSR_UNUSED, '1);
      for (int i = 0; i < 6; i++) begin
         req_calm = (i % 2 == 0);
         rsp_calm = (i % 3 == 0);
         set_frame(sweep_w[i], sweep_h[i], sweep_s[i]);
         feed_frame(sweep_w[i], sweep_h[i], sweep_p[i]);
      end

      // oversized sizes clamp to the store depth and the tallest frame; the
      // frame is then shrunk mid-row, so the column reached counts as the last
      // one and the next row closes the frame
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      set_frame(4095, 8191, 0);
      feed_pixels(60, 70);
      set_frame(3, 2, 1);
      feed_pixels(4, 70);
      frames_run++;

      // random frames, mostly small and dense enough to have interiors
      rand_start = pixels_fed;
      while (pixels_fed - rand_start < RAND_PIXELS) begin
         w = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 20) : $urandom_range(1, 40);
         h = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 8) : $urandom_range(1, 12);
         case ($urandom_range(0, 4))
            0:       s = 0;
            1:       s = $urandom_range(0, 255);
            default: s = $urandom_range(1, 4);
         endcase
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 15) == 0)
            write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
         set_frame(w, h, s);
         feed_frame(w, h, fill_pct[$urandom_range(0, 4)]);
      end

      $display("covered %0d frames, %0d pixel words, %0d result words checked",
               frames_run, pixels_fed, words_checked);
      $display("%0d pixels kept, %0d interior pixels thinned off the grid",
               kept_count, grid_dropped);
      if (fail_count == 0)
         $display("binary_interior_grid_thinning regression: pass");
      else
         $display("binary_interior_grid_thinning regression: fail");
      $finish;
   end

endmodule
